### rtl/core/slem_pkg.sv
package slem_pkg;

  localparam int MAX_KEY_LEN_DEF = 64;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int POS_W           = 16;
  localparam int START_W         = 16;
  localparam int CMP_W           = 33;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [7:0] SEP_CHAR  = 8'h3B;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] SLASH     = 8'h2F;

  typedef enum logic [1:0] {
    CMD_CLEAR_KEY  = 2'd0,
    CMD_APPEND_KEY = 2'd1,
    CMD_SEQ_BYTE   = 2'd2,
    CMD_EMPTY_SEQ  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_PATH_MODE    = 1'b0,
    REG_START_OFFSET = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] character;
    logic       last;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             key_too_long;
    logic             sequence_too_long;
  } rsp_t;

  typedef struct packed {
    logic               path_mode;
    logic [START_W-1:0] start_offset;
  } cfg_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic path_mode);
    logic [7:0] r;
    r = c;
    if (path_mode && c == BACKSLASH) begin
      r = SLASH;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic has_result(input req_t w);
    return (w.command == CMD_EMPTY_SEQ) || (w.command == CMD_SEQ_BYTE && w.last);
  endfunction

endpackage

### rtl/core/slem_ram.sv
module slem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/slem_engine.sv
module slem_engine #(
  parameter int MAX_KEY_LEN = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  slem_pkg::req_t item,
  input  slem_pkg::cfg_t cfg,
  output logic          res_valid,
  output slem_pkg::rsp_t res
);
  import slem_pkg::*;

  localparam int KIDX_W = $clog2(MAX_KEY_LEN + 1);
  localparam int AW     = $clog2(MAX_KEY_LEN);
  localparam int OFS_W  = OFFSET_BITS + 1;

  logic [KIDX_W-1:0]      key_length, key_length_next;
  logic                   key_overflow, key_overflow_next;
  logic [OFS_W-1:0]       byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] part_start, part_start_next;
  logic [KIDX_W-1:0]      compare_index, compare_index_next;
  logic                   in_part, in_part_next;
  logic                   part_mismatch, part_mismatch_next;
  logic                   match_done, match_done_next;
  logic [OFFSET_BITS-1:0] match_offset, match_offset_next;
  logic                   sequence_ended, sequence_ended_next;
  logic                   seq_overflow, seq_overflow_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_q;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    key_byte;
  logic [7:0]    f;

  slem_ram #(
    .WIDTH(8),
    .DEPTH(MAX_KEY_LEN)
  ) u_key_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(item.character),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // key byte for the next compare was fetched last cycle; patch a same-cycle write
  assign key_byte = fwd_hit ? fwd_data : ram_q;
  assign f        = fold(item.character, cfg.path_mode);
  assign wr_addr  = key_length[AW-1:0];

  always_comb begin
    key_length_next     = key_length;
    key_overflow_next   = key_overflow;
    byte_offset_next    = byte_offset;
    part_start_next     = part_start;
    compare_index_next  = compare_index;
    in_part_next        = in_part;
    part_mismatch_next  = part_mismatch;
    match_done_next     = match_done;
    match_offset_next   = match_offset;
    sequence_ended_next = sequence_ended;
    seq_overflow_next   = seq_overflow;
    wr_en               = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;

    if (accept) begin
      case (item.command)
        CMD_CLEAR_KEY: begin
          key_length_next   = '0;
          key_overflow_next = 1'b0;
        end
        CMD_APPEND_KEY: begin
          if (key_length < KIDX_W'(MAX_KEY_LEN)) begin
            wr_en           = 1'b1;
            key_length_next = key_length + 1'b1;
          end else begin
            key_overflow_next = 1'b1;
          end
        end
        CMD_EMPTY_SEQ: begin
          res_valid        = 1'b1;
          res.key_too_long = key_overflow;
          byte_offset_next    = '0;
          part_start_next     = '0;
          compare_index_next  = '0;
          in_part_next        = 1'b0;
          part_mismatch_next  = 1'b0;
          match_done_next     = 1'b0;
          match_offset_next   = '0;
          sequence_ended_next = 1'b0;
          seq_overflow_next   = 1'b0;
        end
        CMD_SEQ_BYTE: begin
          if (!sequence_ended) begin
            if (byte_offset[OFFSET_BITS]) begin
              seq_overflow_next = 1'b1;
            end else if (item.character == 8'h00) begin
              if (in_part && !match_done && !part_mismatch &&
                  compare_index == key_length) begin
                match_done_next   = 1'b1;
                match_offset_next = part_start;
              end
              in_part_next        = 1'b0;
              sequence_ended_next = 1'b1;
            end else begin
              if (CMP_W'(byte_offset) >= CMP_W'(cfg.start_offset) && !match_done) begin
                if (f == SEP_CHAR) begin
                  if (in_part && !part_mismatch && compare_index == key_length) begin
                    match_done_next   = 1'b1;
                    match_offset_next = part_start;
                  end
                  in_part_next = 1'b0;
                end else begin
                  if (!in_part) begin
                    in_part_next       = 1'b1;
                    part_start_next    = byte_offset[OFFSET_BITS-1:0];
                    compare_index_next = '0;
                    part_mismatch_next = 1'b0;
                  end
                  if (!part_mismatch_next) begin
                    if (compare_index_next < key_length &&
                        fold(key_byte, cfg.path_mode) == f) begin
                      compare_index_next = compare_index_next + 1'b1;
                    end else begin
                      part_mismatch_next = 1'b1;
                    end
                  end
                end
              end
              byte_offset_next = byte_offset + 1'b1;
            end
          end

          if (item.last) begin
            // close the open part, then report and drop the sequence state
            if (in_part_next && !match_done_next && !part_mismatch_next &&
                compare_index_next == key_length) begin
              match_done_next   = 1'b1;
              match_offset_next = part_start_next;
            end
            res_valid             = 1'b1;
            res.key_too_long      = key_overflow;
            res.sequence_too_long = seq_overflow_next;
            if (!key_overflow && !seq_overflow_next) begin
              if (key_length == '0) begin
                res.found = 1'b1;
              end else if (match_done_next) begin
                res.found    = 1'b1;
                res.position = POS_W'(match_offset_next);
              end
            end
            byte_offset_next    = '0;
            part_start_next     = '0;
            compare_index_next  = '0;
            in_part_next        = 1'b0;
            part_mismatch_next  = 1'b0;
            match_done_next     = 1'b0;
            match_offset_next   = '0;
            sequence_ended_next = 1'b0;
            seq_overflow_next   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // fetch the key byte the following word will compare against
    rd_addr = in_part_next ? compare_index_next[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= '0;
      key_overflow   <= 1'b0;
      byte_offset    <= '0;
      part_start     <= '0;
      compare_index  <= '0;
      in_part        <= 1'b0;
      part_mismatch  <= 1'b0;
      match_done     <= 1'b0;
      match_offset   <= '0;
      sequence_ended <= 1'b0;
      seq_overflow   <= 1'b0;
      fwd_hit        <= 1'b0;
    end else begin
      key_length     <= key_length_next;
      key_overflow   <= key_overflow_next;
      byte_offset    <= byte_offset_next;
      part_start     <= part_start_next;
      compare_index  <= compare_index_next;
      in_part        <= in_part_next;
      part_mismatch  <= part_mismatch_next;
      match_done     <= match_done_next;
      match_offset   <= match_offset_next;
      sequence_ended <= sequence_ended_next;
      seq_overflow   <= seq_overflow_next;
      fwd_hit        <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= item.character;
  end

endmodule

### rtl/core/separated_list_element_match_top.sv
// Whole-part matcher for ';'-separated lists, case-insensitive. Load a key with
// append words (after a clear), then stream sequence bytes; one result word comes
// out on the byte marked last, or on an empty-sequence word. The block takes one
// word every clock cycle: the key byte that the next sequence byte compares
// against is read from the key RAM ahead of time, with a write to the same
// entry forwarded, so no word waits on the RAM. A result sits in an output
// register; words that make no result keep flowing while it waits, and a word
// that makes one is held off only while that register is full and stalled. The
// key RAM needs no clearing pass after reset. Registers: path_mode at 0x0,
// start_offset at 0x4; write only while the block is idle.
module separated_list_element_match_top #(
  parameter int MAX_KEY_LEN = slem_pkg::MAX_KEY_LEN_DEF,
  parameter int OFFSET_BITS = slem_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  slem_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output slem_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slem_pkg::PADDR_W-1:0]  paddr,
  input  logic [slem_pkg::PDATA_W-1:0]  pwdata,
  output logic [slem_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import slem_pkg::*;

  cfg_t cfg;
  logic accept;
  logic res_valid;
  rsp_t res;

  assign pready    = 1'b1;
  assign req_stall = rsp_valid && rsp_stall && has_result(req);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.path_mode    <= 1'b1;
      cfg.start_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_PATH_MODE:    cfg.path_mode    <= pwdata[0];
        REG_START_OFFSET: cfg.start_offset <= pwdata[START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_PATH_MODE:    prdata = PDATA_W'(cfg.path_mode);
      REG_START_OFFSET: prdata = PDATA_W'(cfg.start_offset);
      default:          prdata = '0;
    endcase
  end

  slem_engine #(
    .MAX_KEY_LEN(MAX_KEY_LEN),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (req),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import slem_pkg::*;

  localparam int KEY_DEPTH  = MAX_KEY_LEN_DEF;
  localparam int SEQ_LIMIT  = 1 << OFFSET_BITS_DEF;
  localparam int IDLE_PCT   = 35;
  localparam int SETTLE_CYC = 8;
  localparam int CFG_EVERY  = 150;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  separated_list_element_match_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Matcher state as the testbench sees it
  logic               cfg_path = 1'b1;
  logic [START_W-1:0] cfg_start = '0;
  logic [7:0]         key_mem [KEY_DEPTH];
  int unsigned        key_len = 0;
  bit                 key_ovf = 1'b0;
  int unsigned        seq_off = 0;
  int unsigned        part_pos = 0;
  int unsigned        cmp_idx = 0;
  int unsigned        hit_pos = 0;
  bit                 in_part = 1'b0;
  bit                 part_bad = 1'b0;
  bit                 hit = 1'b0;
  bit                 seq_done = 1'b0;
  bit                 seq_ovf = 1'b0;

  rsp_t               pending_matches[$];
  int                 mismatch_count = 0;
  int                 words_sent = 0;
  bit                 calm = 1'b0;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (cfg_path && c == BACKSLASH) begin
      return SLASH;
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic void restart_scan();
    seq_off  = 0;
    part_pos = 0;
    cmp_idx  = 0;
    hit_pos  = 0;
    in_part  = 1'b0;
    part_bad = 1'b0;
    hit      = 1'b0;
    seq_done = 1'b0;
    seq_ovf  = 1'b0;
  endfunction

  function automatic void close_part();
    if (in_part && !hit && !part_bad && cmp_idx == key_len) begin
      hit     = 1'b1;
      hit_pos = part_pos;
    end
    in_part = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic [7:0] f;
    if (seq_off >= SEQ_LIMIT) begin
      seq_ovf = 1'b1;
      return;
    end
    if (c == 8'h00) begin
      close_part();
      seq_done = 1'b1;
      return;
    end
    if (seq_off >= cfg_start && !hit) begin
      f = fold_char(c);
      if (f == SEP_CHAR) begin
        close_part();
      end else begin
        if (!in_part) begin
          in_part  = 1'b1;
          part_pos = seq_off;
          cmp_idx  = 0;
          part_bad = 1'b0;
        end
        if (!part_bad) begin
          if (cmp_idx < key_len && fold_char(key_mem[cmp_idx]) == f) begin
            cmp_idx++;
          end else begin
            part_bad = 1'b1;
          end
        end
      end
    end
    seq_off++;
  endfunction

  function automatic void predict_match(input req_t w);
    rsp_t r;
    r = '0;
    case (w.command)
      CMD_CLEAR_KEY: begin
        key_len = 0;
        key_ovf = 1'b0;
      end
      CMD_APPEND_KEY: begin
        if (key_len < KEY_DEPTH) begin
          key_mem[key_len] = w.character;
          key_len++;
        end else begin
          key_ovf = 1'b1;
        end
      end
      CMD_EMPTY_SEQ: begin
        r.key_too_long = key_ovf;
        pending_matches.push_back(r);
        restart_scan();
      end
      default: begin
        if (!seq_done) begin
          scan_byte(w.character);
        end
        if (w.last) begin
          close_part();
          if (!key_ovf && !seq_ovf) begin
            if (key_len == 0) begin
              r.found = 1'b1;
            end else if (hit) begin
              r.found    = 1'b1;
              r.position = POS_W'(hit_pos);
            end
          end
          r.key_too_long      = key_ovf;
          r.sequence_too_long = seq_ovf;
          pending_matches.push_back(r);
          restart_scan();
        end
      end
    endcase
  endfunction

  // Result side: check each accepted word, then pick the next stall
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_matches.size() == 0) begin
        $error("result word with no pending match: %h", rsp);
        mismatch_count++;
      end else begin
        want = pending_matches.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp.found);
          mismatch_count++;
        end
        if (rsp.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp.position);
          mismatch_count++;
        end
        if (rsp.key_too_long !== want.key_too_long) begin
          $error("key_too_long: expected %0d, got %0d", want.key_too_long, rsp.key_too_long);
          mismatch_count++;
        end
        if (rsp.sequence_too_long !== want.sequence_too_long) begin
          $error("sequence_too_long: expected %0d, got %0d",
                 want.sequence_too_long, rsp.sequence_too_long);
          mismatch_count++;
        end
      end
    end
    rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Valid stays high after acceptance; anything that lets time pass drops it first
  task automatic send_word(input cmd_t cmd, input logic [7:0] ch, input logic lst);
    req_t w;
    w.command   = cmd;
    w.character = ch;
    w.last      = lst;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    predict_match(w);
    words_sent++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    req_valid <= 1'b0;
    psel      <= 1'b1;
    penable   <= 1'b0;
    pwrite    <= 1'b1;
    paddr     <= PADDR_W'(int'(idx) * 4);
    pwdata    <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_PATH_MODE) begin
      cfg_path = val[0];
    end else begin
      cfg_start = val[START_W-1:0];
    end
  endtask

  task automatic set_config(input logic pm, input logic [START_W-1:0] so);
    settle();
    write_reg(REG_PATH_MODE, PDATA_W'(pm));
    write_reg(REG_START_OFFSET, PDATA_W'(so));
  endtask

  task automatic load_key(input string s);
    send_word(CMD_CLEAR_KEY, 8'($urandom_range(255)), 1'($urandom_range(1)));
    for (int i = 0; i < s.len(); i++) begin
      send_word(CMD_APPEND_KEY, s[i], 1'($urandom_range(1)));
    end
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_word(CMD_SEQ_BYTE, s[i], close && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] key_char();
    logic [7:0] pool [8];
    pool = '{8'h61, 8'h42, 8'h63, SLASH, BACKSLASH, 8'h2E, 8'h78, 8'h59};
    return pool[$urandom_range(7)];
  endfunction

  // Same character as far as the matcher can tell in path mode, in a random spelling
  function automatic logic [7:0] respell(input logic [7:0] c);
    if ($urandom_range(1) == 0) begin
      return c;
    end
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      return c ^ 8'h20;
    end
    if (c == SLASH) begin
      return BACKSLASH;
    end
    if (c == BACKSLASH) begin
      return SLASH;
    end
    return c;
  endfunction

  function automatic logic [START_W-1:0] pick_start();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return '1;
    end
    if (r == 1) begin
      return START_W'($urandom_range(65535));
    end
    return START_W'($urandom_range(6));
  endfunction

  task automatic random_key();
    int n;
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
    send_word(CMD_CLEAR_KEY, 8'($urandom_range(255)), 1'($urandom_range(1)));
    for (int i = 0; i < n; i++) begin
      send_word(CMD_APPEND_KEY, key_char(), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_sequence();
    logic [7:0] seq_q[$];
    int         nparts;
    int         kind;
    int         ending;
    int         cut;
    seq_q = {};
    if ($urandom_range(3) == 0) begin
      seq_q.push_back(SEP_CHAR);
    end
    nparts = $urandom_range(4);
    for (int p = 0; p < nparts; p++) begin
      kind = $urandom_range(9);
      if (kind < 4 && key_len > 0) begin
        for (int i = 0; i < key_len; i++) begin
          seq_q.push_back(respell(key_mem[i]));
        end
        // near misses: one byte short or one byte long
        if ($urandom_range(5) == 0) begin
          void'(seq_q.pop_back());
        end else if ($urandom_range(5) == 0) begin
          seq_q.push_back(key_char());
        end
      end else if (kind >= 5) begin
        repeat ($urandom_range(5, 1)) begin
          seq_q.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255, 1)) : key_char());
        end
      end
      if (p != nparts - 1 || $urandom_range(3) == 0) begin
        seq_q.push_back(SEP_CHAR);
      end
    end
    if ($urandom_range(9) == 0) begin
      seq_q.insert($urandom_range(seq_q.size()), 8'h00);
    end
    if (seq_q.size() == 0) begin
      seq_q.push_back(SEP_CHAR);
    end
    ending = $urandom_range(19);
    cut    = $urandom_range(seq_q.size());
    for (int i = 0; i < seq_q.size(); i++) begin
      if (ending == 1 && i == cut) begin
        random_key();
      end
      send_word(CMD_SEQ_BYTE, seq_q[i], ending != 0 && i == seq_q.size() - 1);
    end
    if (ending == 0) begin
      send_word(CMD_EMPTY_SEQ, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_empty_cases();
    send_word(CMD_EMPTY_SEQ, 8'hFF, 1'b1);
    send_text("x", 1'b1);
    send_word(CMD_SEQ_BYTE, 8'h00, 1'b1);
  endtask

  task automatic test_folding();
    load_key("A\\");
    send_text(";;b;a/", 1'b1);
    set_config(1'b0, '0);
    send_text("a/;A\\", 1'b1);
    set_config(1'b1, '0);
  endtask

  task automatic test_sequence_edges();
    load_key("ab");
    // NUL closes the open part; the byte after it is dropped
    send_text("x;a", 1'b0);
    send_word(CMD_SEQ_BYTE, 8'h00, 1'b0);
    send_text("b", 1'b1);
    // abandon a sequence in progress
    send_text("ab", 1'b0);
    send_word(CMD_EMPTY_SEQ, 8'h00, 1'b0);
    // swap the key under an open part that is already too long
    send_text("ab", 1'b0);
    load_key("a");
    send_text(";A", 1'b1);
  endtask

  task automatic test_start_offset();
    set_config(1'b1, START_W'(2));
    load_key("cd");
    send_text("xbcd", 1'b1);
    set_config(1'b1, START_W'(9));
    send_text("abcd", 1'b1);
    set_config(1'b1, '0);
  endtask

  task automatic test_key_limits();
    send_word(CMD_CLEAR_KEY, 8'h00, 1'b0);
    for (int i = 0; i < KEY_DEPTH; i++) begin
      send_word(CMD_APPEND_KEY, 8'(8'h41 + (i % 26)), 1'b0);
    end
    send_word(CMD_SEQ_BYTE, SEP_CHAR, 1'b0);
    for (int i = 0; i < KEY_DEPTH; i++) begin
      send_word(CMD_SEQ_BYTE, 8'(8'h61 + (i % 26)), i == KEY_DEPTH - 1);
    end
    // one byte too many: flag holds until the key is cleared
    send_word(CMD_APPEND_KEY, 8'h61, 1'b1);
    send_text("a", 1'b1);
    send_word(CMD_EMPTY_SEQ, 8'h00, 1'b0);
    send_word(CMD_CLEAR_KEY, 8'hFF, 1'b1);
    send_word(CMD_EMPTY_SEQ, 8'h00, 1'b1);
  endtask

  task automatic test_random_traffic(input int n);
    int first;
    int next_cfg;
    int r;
    bit paused;
    first    = words_sent;
    next_cfg = words_sent;
    paused   = 1'b0;
    random_key();
    while (words_sent - first < n) begin
      if (words_sent >= next_cfg) begin
        set_config(1'($urandom_range(1)), pick_start());
        next_cfg += CFG_EVERY;
      end
      calm = (words_sent - first >= 300) && (words_sent - first < 450);
      // hold off until every pending match has come back
      if (!paused && words_sent - first >= n / 2) begin
        settle();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 15) begin
        random_key();
      end else if (r < 85) begin
        random_sequence();
      end else begin
        send_word(cmd_t'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_cases();
    test_folding();
    test_sequence_edges();
    test_start_offset();
    test_key_limits();
    test_random_traffic(720);
    settle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/slem_pkg.sv
rtl/core/slem_ram.sv
rtl/core/slem_engine.sv
rtl/core/separated_list_element_match_top.sv
tb/sv/tb_top.sv
